// File: rtl/core/stc_pkg.sv
// Shared types and constants for the space-to-tab compressor.
package stc_pkg;

  localparam int unsigned MAX_STOPS  = 8;
  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned FIELD_W    = 6;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;

  // configuration register indexes
  localparam logic REG_STOP_WIDTHS = 1'b0;
  localparam logic REG_STOP_COUNT  = 1'b1;

  // one queued command: a run of leading blanks, then optionally the byte itself
  typedef struct packed {
    logic       lead_tab;
    logic [6:0] lead_n;
    logic       has_char;
    logic [7:0] ch;
  } stc_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stc_q_status_t;

endpackage

// File: rtl/core/stc_front.sv
// Front end: line position tracking, stop handling and command generation.
module stc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [47:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char,
  input  stc_pkg::stc_q_status_t q_status,
  output logic              q_push,
  output stc_pkg::stc_cmd_t q_cmd
);
  import stc_pkg::*;

  logic [47:0] stop_widths_r;
  logic [3:0]  stop_count_r;
  logic [5:0]  column_r, column_nxt;
  logic [6:0]  pending_r, pending_nxt;
  logic [2:0]  stop_index_r, stop_index_nxt;
  logic        past_r, past_nxt;

  logic [5:0]  fields [MAX_STOPS];
  logic [3:0]  cnt_eff;
  logic        multi;
  logic [2:0]  idx;
  logic [6:0]  w_raw, w_cur, col_plus;
  logic        wrap, adv_past, is_sp, blank, col0, accept;
  stc_cmd_t    cmd;

  for (genvar g = 0; g < MAX_STOPS; g++) begin : g_fields
    assign fields[g] = stop_widths_r[g*FIELD_W +: FIELD_W];
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    if (stop_count_r == 4'd0)
      cnt_eff = 4'd1;
    else if (stop_count_r > 4'(MAX_STOPS))
      cnt_eff = 4'(MAX_STOPS);
    else
      cnt_eff = stop_count_r;
  end

  assign multi    = cnt_eff > 4'd1;
  assign idx      = multi ? stop_index_r : 3'd0;
  assign w_raw    = {1'b0, fields[idx]} + 7'd1;
  assign w_cur    = (w_raw > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : w_raw;
  assign col_plus = {1'b0, column_r} + 7'd1;
  assign wrap     = col_plus >= w_cur;
  assign adv_past = multi && (({1'b0, stop_index_r} + 4'd1) >= cnt_eff);

  assign is_sp = in_char == CH_SP;
  assign blank = is_sp || (in_char == CH_TAB);
  assign col0  = column_r == 6'd0;

  always_comb begin
    cmd          = '0;
    cmd.ch       = in_char;
    // held-back spaces
    if (col0) begin
      if (pending_r > 7'd1 || (pending_r == 7'd1 && blank)) begin
        cmd.lead_tab = 1'b1;
        cmd.lead_n   = 7'd1;
      end else if (pending_r == 7'd1) begin
        cmd.lead_n   = 7'd1;
      end
    end else if (!blank) begin
      cmd.lead_n = (pending_r > 7'(RESULT_CAP)) ? 7'(RESULT_CAP) : pending_r;
    end
    cmd.has_char = (past_r || !is_sp) && (cmd.lead_n < 7'(RESULT_CAP));

    column_nxt     = column_r;
    pending_nxt    = pending_r;
    stop_index_nxt = stop_index_r;
    past_nxt       = past_r;
    if (past_r) begin
      pending_nxt = 7'd0;
      column_nxt  = 6'd0;
      if (in_char == CH_NL) begin
        stop_index_nxt = 3'd0;
        past_nxt       = 1'b0;
      end
    end else begin
      if (!is_sp)
        pending_nxt = 7'd0;
      else if (col0)
        pending_nxt = 7'd1;
      else if (pending_r != 7'd127)
        pending_nxt = pending_r + 7'd1;

      if (in_char == CH_TAB || (in_char != CH_NL && wrap)) begin
        column_nxt = 6'd0;
        if (adv_past)
          past_nxt = 1'b1;
        else if (multi)
          stop_index_nxt = stop_index_r + 3'd1;
      end else if (in_char == CH_NL) begin
        column_nxt     = 6'd0;
        stop_index_nxt = 3'd0;
        past_nxt       = 1'b0;
      end else begin
        column_nxt = column_r + 6'd1;
      end
    end
  end

  assign q_push = accept && (cmd.lead_n != 7'd0 || cmd.has_char);
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_widths_r <= 48'd7;
      stop_count_r  <= 4'd1;
      column_r      <= '0;
      pending_r     <= '0;
      stop_index_r  <= '0;
      past_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STOP_WIDTHS: stop_widths_r <= cfg_data;
          REG_STOP_COUNT:  stop_count_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        column_r     <= column_nxt;
        pending_r    <= pending_nxt;
        stop_index_r <= stop_index_nxt;
        past_r       <= past_nxt;
      end
    end
  end

endmodule

// File: rtl/core/stc_queue.sv
// Small command queue between the front and back ends.
module stc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  stc_pkg::stc_cmd_t       push_cmd,
  input  logic                    pop,
  output stc_pkg::stc_cmd_t       head_cmd,
  output stc_pkg::stc_q_status_t  status
);
  import stc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  stc_cmd_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   fill_r;
  logic               do_push, do_pop;

  assign status.full  = fill_r == CNT_W'(DEPTH);
  assign status.empty = fill_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)
        fill_r <= fill_r + 1'b1;
      else if (do_pop && !do_push)
        fill_r <= fill_r - 1'b1;
    end
  end

endmodule

// File: rtl/core/stc_back.sv
// Back end: expands queued commands into output beats.
module stc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  stc_pkg::stc_q_status_t q_status,
  input  stc_pkg::stc_cmd_t      head_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_char,
  output logic                   out_last
);
  import stc_pkg::*;

  logic [6:0] cnt_r;
  logic       out_valid_r, out_last_r;
  logic [7:0] out_char_r;
  logic       fire, lead_left, beat_last;
  logic [7:0] beat_char;

  assign fire      = !q_status.empty && (!out_valid_r || !out_stall);
  assign lead_left = cnt_r != head_cmd.lead_n;
  assign beat_char = lead_left ? (head_cmd.lead_tab ? CH_TAB : CH_SP) : head_cmd.ch;
  assign beat_last = lead_left ? ((cnt_r + 7'd1 == head_cmd.lead_n) && !head_cmd.has_char)
                               : 1'b1;
  assign q_pop     = fire && beat_last;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char_r <= beat_char;
      out_last_r <= beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (fire)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
      if (fire)
        cnt_r <= beat_last ? 7'd0 : cnt_r + 7'd1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/core/space_to_tab_compressor.sv
// Space-to-tab compressor: turns runs of spaces that reach a tab stop into tabs.
// One text byte is taken per cycle while the command queue is not full. The
// front end updates the line position and stop state in the cycle a byte is
// taken and queues one command per byte that produces output; the back end
// sends one beat per cycle from its output register unless out_stall holds it.
// A byte that causes n result beats (n up to 64, the flush of held spaces plus
// the byte itself) occupies the back end until its last beat, so input keeps
// flowing at one byte per cycle until the QUEUE_DEPTH-entry command queue
// fills behind a long flush. Bytes that are only held back take no queue entry.
// The user must write configuration only while the block is idle; the block
// does not enforce this, and there is no clearing pass after reset.
module space_to_tab_compressor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last
);
  import stc_pkg::*;

  stc_q_status_t q_status;
  stc_cmd_t      push_cmd, head_cmd;
  logic          q_push, q_pop;

  stc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  stc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .head_cmd(head_cmd),
    .status  (q_status)
  );

  stc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .head_cmd (head_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char (out_char),
    .out_last (out_last)
  );

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_status.full))
    else $error("command pushed into full queue");

  // a beat that is not the last of its byte leaves its command at the queue head
  a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !q_status.empty)
    else $error("command popped before its last beat");

  // nothing is presented straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
